FILE: design/q106_pkg.sv
// Shared types and constants for the Q10.6 fixed-point arithmetic unit.
// No dependencies; used by the divider stages, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package q106_pkg;

    localparam int DATA_W = 16;

    typedef enum logic [2:0] {
        FUNC_ADD      = 3'd0,
        FUNC_SUB      = 3'd1,
        FUNC_MUL      = 3'd2,
        FUNC_DIV      = 3'd3,
        FUNC_EQUAL    = 3'd4,
        FUNC_TO_INT   = 3'd5,
        FUNC_FROM_INT = 3'd6
    } func_t;

    // Sideband that rides along the divider pipeline.
    typedef struct packed {
        logic [DATA_W-1:0] result;       // final result for every non-divide op
        logic              is_equal;
        logic              is_div;
        logic              div_by_zero;
        logic              neg_q;        // quotient must be negated
    } q106_tag_t;

endpackage

`default_nettype wire

FILE: design/q10_6_fixed_point_alu.sv
// Top level of the Q10.6 fixed-point arithmetic unit.
// Depends on q106_pkg and q106_divider (which uses q106_div_stage).
//
// Usage:
//   Input channel s_*: one transaction carries an operation (s_tuser) and two
//   signed raw operands (s_tdata). Output channel m_*: one transaction per
//   input with the 16-bit result in m_tdata and the equal / divide-by-zero
//   flags in m_tuser.
//   Every operation goes through the same pipeline, so results leave in
//   input order. The path is an operand prep and multiply register,
//   16 + FRACTION_BITS divider stages (one quotient bit per stage, restoring
//   subtract), and the output register. Throughput is one transaction per
//   cycle while the receiver does not stall; the serial quotient chain sets
//   the depth, not the rate.
//   Reset (aresetn low, synchronous) clears every stage valid bit and the
//   output valid; data registers are not reset.
//   When the receiver stalls, the whole pipeline freezes together, s_tready
//   drops, and nothing is dropped or repeated. s_tready stays high while the
//   output register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none

module q10_6_fixed_point_alu #(
    parameter int FRACTION_BITS = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] operand_a, [31:16] operand_b
    input  wire logic [7:0]  s_tuser,   // [2:0] func, [7:3] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] result
    output logic [7:0]       m_tuser    // [0] is_equal, [1] div_by_zero, [7:2] zero
);

    localparam int NUM_W = 16 + FRACTION_BITS;
    localparam logic [16:0] TO_INT_BIAS = 17'((1 << FRACTION_BITS) - 1);

    logic en;

    // ---- input decode ----
    logic signed [15:0] op_a, op_b;
    q106_pkg::func_t    func;
    logic [15:0]        a_mag, b_mag;
    logic signed [16:0] to_int_sum;
    logic [15:0]        simple_res;

    assign op_a = s_tdata[15:0];
    assign op_b = s_tdata[31:16];
    assign func = q106_pkg::func_t'(s_tuser[2:0]);
    assign en   = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        a_mag = op_a[15] ? 16'(-op_a) : op_a;
        b_mag = op_b[15] ? 16'(-op_b) : op_b;
        // to-int truncates toward zero: bias negatives before the shift
        to_int_sum = {op_a[15], op_a} + (op_a[15] ? TO_INT_BIAS : 17'd0);
        case (func)
            q106_pkg::FUNC_ADD:      simple_res = 16'(op_a + op_b);
            q106_pkg::FUNC_SUB:      simple_res = 16'(op_a - op_b);
            q106_pkg::FUNC_TO_INT:   simple_res = 16'(to_int_sum >>> FRACTION_BITS);
            q106_pkg::FUNC_FROM_INT: simple_res = 16'(op_a << FRACTION_BITS);
            default:                 simple_res = '0;
        endcase
    end

    // ---- stage 1: multiply and operand prep ----
    logic                 s1_valid_reg;
    logic signed [31:0]   prod_reg;
    logic [15:0]          simple_reg;
    logic                 is_mul_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [15:0]          den_reg;
    q106_pkg::q106_tag_t  s1_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= op_a * op_b;
            simple_reg  <= simple_res;
            is_mul_reg  <= (func == q106_pkg::FUNC_MUL);
            num_reg     <= {a_mag, {FRACTION_BITS{1'b0}}};
            den_reg     <= b_mag;
            s1_tag_reg.result      <= '0;
            s1_tag_reg.is_equal    <= (func == q106_pkg::FUNC_EQUAL) && (op_a == op_b);
            s1_tag_reg.is_div      <= (func == q106_pkg::FUNC_DIV);
            s1_tag_reg.div_by_zero <= (func == q106_pkg::FUNC_DIV) && (op_b == 16'sd0);
            s1_tag_reg.neg_q       <= op_a[15] ^ op_b[15];
        end
    end

    // multiply: product shifted right by the fraction width, low 16 bits kept; other ops pass their simple result
    q106_pkg::q106_tag_t div_tag;
    always_comb begin
        div_tag = s1_tag_reg;
        div_tag.result = is_mul_reg ? prod_reg[FRACTION_BITS+15:FRACTION_BITS] : simple_reg;
    end

    // ---- divider pipeline ----
    logic                div_valid;
    logic [15:0]         quot;
    q106_pkg::q106_tag_t out_tag;

    q106_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s1_valid_reg),
        .num_in    (num_reg),
        .den_in    (den_reg),
        .tag_in    (div_tag),
        .valid_out (div_valid),
        .quot_out  (quot),
        .tag_out   (out_tag)
    );

    // ---- output register ----
    logic        m_valid_reg;
    logic [15:0] m_data_reg, m_data_next;
    logic [1:0]  m_flags_reg;

    always_comb begin
        if (!out_tag.is_div) begin
            m_data_next = out_tag.result;
        end else if (out_tag.div_by_zero) begin
            m_data_next = '0;
        end else begin
            m_data_next = out_tag.neg_q ? 16'(-quot) : quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg  <= m_data_next;
            m_flags_reg <= {out_tag.div_by_zero, out_tag.is_equal};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {6'd0, m_flags_reg};

    // ---- assertions ----
    a_dz_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 16'd0)
        else $error("divide by zero with nonzero result");

    a_eq_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0 && !m_tuser[1])
        else $error("equal flag with nonzero result or divide flag");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output register");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s1_valid_reg) && $stable(div_valid))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

FILE: design/q106_div_stage.sv
// One restoring-division iteration with its pipeline register.
// Depends on q106_pkg for the sideband tag type.
`timescale 1ns / 1ps
`default_nettype none

module q106_div_stage #(
    parameter int NUM_W = 22
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    valid_in,
    input  wire logic [15:0]             rem_in,
    input  wire logic [NUM_W-1:0]        numq_in,
    input  wire logic [15:0]             den_in,
    input  wire q106_pkg::q106_tag_t     tag_in,
    output logic                         valid_out,
    output logic [15:0]                  rem_out,
    output logic [NUM_W-1:0]             numq_out,
    output logic [15:0]                  den_out,
    output q106_pkg::q106_tag_t          tag_out
);

    logic [16:0]       shifted;
    logic [16:0]       trial;
    logic              valid_reg;
    logic [15:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]  numq_reg, numq_next;
    logic [15:0]       den_reg;
    q106_pkg::q106_tag_t tag_reg;

    always_comb begin
        shifted   = {rem_in, numq_in[NUM_W-1]};
        trial     = shifted - {1'b0, den_in};
        // borrow out means the trial subtract went negative: restore
        rem_next  = trial[16] ? shifted[15:0] : trial[15:0];
        numq_next = {numq_in[NUM_W-2:0], ~trial[16]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            numq_reg <= numq_next;
            den_reg  <= den_in;
            tag_reg  <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign numq_out  = numq_reg;
    assign den_out   = den_reg;
    assign tag_out   = tag_reg;

endmodule

`default_nettype wire

FILE: design/q106_divider.sv
// Pipelined restoring divider, one quotient bit per stage, carrying a sideband tag.
// Depends on q106_pkg and q106_div_stage.
`timescale 1ns / 1ps
`default_nettype none

module q106_divider #(
    parameter int NUM_W = 22
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire logic [NUM_W-1:0]    num_in,   // dividend magnitude
    input  wire logic [15:0]         den_in,   // divisor magnitude
    input  wire q106_pkg::q106_tag_t tag_in,
    output logic                     valid_out,
    output logic [15:0]              quot_out, // low bits of quotient magnitude
    output q106_pkg::q106_tag_t      tag_out
);

    logic                 valid_w [NUM_W+1];
    logic [15:0]          rem_w   [NUM_W+1];
    logic [NUM_W-1:0]     numq_w  [NUM_W+1];
    logic [15:0]          den_w   [NUM_W+1];
    q106_pkg::q106_tag_t  tag_w   [NUM_W+1];

    assign valid_w[0] = valid_in;
    assign rem_w[0]   = '0;
    assign numq_w[0]  = num_in;
    assign den_w[0]   = den_in;
    assign tag_w[0]   = tag_in;

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        q106_div_stage #(
            .NUM_W (NUM_W)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_w[i]),
            .rem_in    (rem_w[i]),
            .numq_in   (numq_w[i]),
            .den_in    (den_w[i]),
            .tag_in    (tag_w[i]),
            .valid_out (valid_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .numq_out  (numq_w[i+1]),
            .den_out   (den_w[i+1]),
            .tag_out   (tag_w[i+1])
        );
    end

    assign valid_out = valid_w[NUM_W];
    assign quot_out  = numq_w[NUM_W][15:0];
    assign tag_out   = tag_w[NUM_W];

endmodule

`default_nettype wire
